// File: rtl/core/lalrb_pkg.sv
// Shared constants, codes and types for the line-aligned log ring buffer.
`default_nettype none

package lalrb_pkg;

  localparam int BUFFER_BYTES = 65536;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int POS_W        = 48;
  localparam int CNT_W        = 32;
  localparam int BYTE_W       = 8;

  localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [POS_W-1:0]  BUF_POS      = POS_W'(BUFFER_BYTES);
  localparam logic [CNT_W-1:0]  BUF_CNT      = CNT_W'(BUFFER_BYTES);

  typedef enum logic [1:0] {
    MODE_APPEND  = 2'd0,
    MODE_READ    = 2'd1,
    MODE_DISCARD = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HELD,
    ST_TRIM,
    ST_SCAN_RD,
    ST_SCAN_WAIT,
    ST_RD_CHK,
    ST_RD_WAIT
  } state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

endpackage

`default_nettype wire

// File: rtl/core/lalrb_ram.sv
// Byte store: single write port, single registered read port.
`default_nettype none

module lalrb_ram (
  input  wire logic                         clk,
  input  wire lalrb_pkg::ram_wr_t           wr,
  input  wire lalrb_pkg::ram_rd_t           rd,
  output logic [lalrb_pkg::BYTE_W-1:0]      rd_data
);

  logic [lalrb_pkg::BYTE_W-1:0] mem [lalrb_pkg::BUFFER_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/line_aligned_log_ring_buffer.sv
// Discard, unused mode and an append not ending a record show in the next cycle; one ending
// a record passes HELD, TRIM, then on wrap SCAN_RD and SCAN_WAIT per byte skipped until
// a newline or head is reached. A read passes RD_CHK, then RD_WAIT when a byte is fetched.
// One request at a time: the next is taken in the cycle its predecessor's result is shown.
// Wrap alignment reads the store one byte at a time (one read port, registered read).
// Reset clears head and tail positions, counters and control; the byte store is not cleared.
`default_nettype none

module line_aligned_log_ring_buffer (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        in_mode,
  input  wire logic [lalrb_pkg::BYTE_W-1:0]      in_data_byte,
  input  wire logic                              in_last_byte,
  input  wire logic [lalrb_pkg::POS_W-1:0]       in_read_position,
  output logic                                   out_valid,
  output logic [lalrb_pkg::BYTE_W-1:0]           out_read_byte,
  output logic                                   out_read_valid,
  output logic [lalrb_pkg::POS_W-1:0]            out_next_position,
  output logic [lalrb_pkg::POS_W-1:0]            out_head_position,
  output logic [lalrb_pkg::POS_W-1:0]            out_tail_position,
  output logic [lalrb_pkg::CNT_W-1:0]            out_dropped_byte_count,
  output logic [lalrb_pkg::CNT_W-1:0]            out_dropped_line_count,
  output logic [lalrb_pkg::CNT_W-1:0]            out_record_count
);

  lalrb_pkg::state_t state_r, state_nxt;

  logic [lalrb_pkg::POS_W-1:0]  head_r, head_nxt;
  logic [lalrb_pkg::POS_W-1:0]  tail_r, tail_nxt;
  logic [lalrb_pkg::CNT_W-1:0]  drop_bytes_r, drop_bytes_nxt;
  logic [lalrb_pkg::CNT_W-1:0]  drop_lines_r, drop_lines_nxt;
  logic [lalrb_pkg::CNT_W-1:0]  records_r, records_nxt;
  logic [lalrb_pkg::POS_W-1:0]  held_r, held_nxt;
  logic [lalrb_pkg::POS_W-1:0]  cursor_r, cursor_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [lalrb_pkg::BYTE_W-1:0] rbyte_r, rbyte_nxt;
  logic                         rvalid_r, rvalid_nxt;
  logic [lalrb_pkg::POS_W-1:0]  next_pos_r, next_pos_nxt;

  lalrb_pkg::ram_wr_t           ram_wr;
  lalrb_pkg::ram_rd_t           ram_rd;
  logic [lalrb_pkg::BYTE_W-1:0] ram_rdata;

  logic accept;
  logic cur_lt_head;
  logic held_over;
  logic scan_empty;
  logic rdata_nl;

  assign busy        = (state_r != lalrb_pkg::ST_IDLE);
  assign accept      = start && !busy;
  assign cur_lt_head = (cursor_r < head_r);
  assign held_over   = (held_r > lalrb_pkg::BUF_POS);
  assign scan_empty  = (tail_r == head_r);
  assign rdata_nl    = (ram_rdata == lalrb_pkg::NEWLINE_CODE);

  lalrb_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lalrb_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (lalrb_pkg::mode_t'(in_mode))
            lalrb_pkg::MODE_APPEND:  state_nxt = in_last_byte ? lalrb_pkg::ST_HELD
                                                              : lalrb_pkg::ST_IDLE;
            lalrb_pkg::MODE_READ:    state_nxt = lalrb_pkg::ST_RD_CHK;
            lalrb_pkg::MODE_DISCARD: state_nxt = lalrb_pkg::ST_IDLE;
            default:                 state_nxt = lalrb_pkg::ST_IDLE;
          endcase
        end
      end
      lalrb_pkg::ST_HELD:      state_nxt = lalrb_pkg::ST_TRIM;
      lalrb_pkg::ST_TRIM:      state_nxt = held_over ? lalrb_pkg::ST_SCAN_RD
                                                     : lalrb_pkg::ST_IDLE;
      lalrb_pkg::ST_SCAN_RD:   state_nxt = scan_empty ? lalrb_pkg::ST_IDLE
                                                      : lalrb_pkg::ST_SCAN_WAIT;
      lalrb_pkg::ST_SCAN_WAIT: state_nxt = rdata_nl ? lalrb_pkg::ST_IDLE
                                                    : lalrb_pkg::ST_SCAN_RD;
      lalrb_pkg::ST_RD_CHK:    state_nxt = cur_lt_head ? lalrb_pkg::ST_RD_WAIT
                                                       : lalrb_pkg::ST_IDLE;
      lalrb_pkg::ST_RD_WAIT:   state_nxt = lalrb_pkg::ST_IDLE;
      default:                 state_nxt = lalrb_pkg::ST_IDLE;
    endcase
  end

  // datapath and store access
  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    drop_bytes_nxt = drop_bytes_r;
    drop_lines_nxt = drop_lines_r;
    records_nxt    = records_r;
    held_nxt       = held_r;
    cursor_nxt     = cursor_r;
    out_valid_nxt  = 1'b0;
    rbyte_nxt      = rbyte_r;
    rvalid_nxt     = rvalid_r;
    next_pos_nxt   = next_pos_r;
    ram_wr.en      = 1'b0;
    ram_wr.addr    = head_r[lalrb_pkg::ADDR_W-1:0];
    ram_wr.data    = in_data_byte;
    ram_rd.en      = 1'b0;
    ram_rd.addr    = tail_r[lalrb_pkg::ADDR_W-1:0];

    unique case (state_r)
      lalrb_pkg::ST_IDLE: begin
        if (accept) begin
          rbyte_nxt    = '0;
          rvalid_nxt   = 1'b0;
          next_pos_nxt = '0;
          unique case (lalrb_pkg::mode_t'(in_mode))
            lalrb_pkg::MODE_APPEND: begin
              ram_wr.en = 1'b1;
              head_nxt  = head_r + lalrb_pkg::POS_W'(1);
              if (in_last_byte) begin
                records_nxt = records_r + lalrb_pkg::CNT_W'(1);
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            lalrb_pkg::MODE_READ: begin
              cursor_nxt = (in_read_position < tail_r) ? tail_r : in_read_position;
            end
            lalrb_pkg::MODE_DISCARD: begin
              tail_nxt      = head_r;
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      lalrb_pkg::ST_HELD: begin
        held_nxt = head_r - tail_r;
      end
      lalrb_pkg::ST_TRIM: begin
        if (held_over) begin
          tail_nxt       = head_r - lalrb_pkg::BUF_POS;
          drop_bytes_nxt = drop_bytes_r + held_r[lalrb_pkg::CNT_W-1:0] - lalrb_pkg::BUF_CNT;
        end else begin
          out_valid_nxt = 1'b1;
        end
      end
      lalrb_pkg::ST_SCAN_RD: begin
        if (scan_empty) begin
          out_valid_nxt = 1'b1;
        end else begin
          ram_rd.en = 1'b1;
        end
      end
      lalrb_pkg::ST_SCAN_WAIT: begin
        tail_nxt       = tail_r + lalrb_pkg::POS_W'(1);
        drop_bytes_nxt = drop_bytes_r + lalrb_pkg::CNT_W'(1);
        if (rdata_nl) begin
          drop_lines_nxt = drop_lines_r + lalrb_pkg::CNT_W'(1);
          out_valid_nxt  = 1'b1;
        end
      end
      lalrb_pkg::ST_RD_CHK: begin
        ram_rd.addr = cursor_r[lalrb_pkg::ADDR_W-1:0];
        if (cur_lt_head) begin
          ram_rd.en = 1'b1;
        end else begin
          next_pos_nxt  = cursor_r;
          out_valid_nxt = 1'b1;
        end
      end
      lalrb_pkg::ST_RD_WAIT: begin
        rbyte_nxt     = ram_rdata;
        rvalid_nxt    = 1'b1;
        next_pos_nxt  = cursor_r + lalrb_pkg::POS_W'(1);
        out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lalrb_pkg::ST_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      drop_bytes_r <= '0;
      drop_lines_r <= '0;
      records_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      drop_bytes_r <= drop_bytes_nxt;
      drop_lines_r <= drop_lines_nxt;
      records_r    <= records_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r     <= held_nxt;
    cursor_r   <= cursor_nxt;
    rbyte_r    <= rbyte_nxt;
    rvalid_r   <= rvalid_nxt;
    next_pos_r <= next_pos_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_read_byte          = rbyte_r;
  assign out_read_valid         = rvalid_r;
  assign out_next_position      = next_pos_r;
  assign out_head_position      = head_r;
  assign out_tail_position      = tail_r;
  assign out_dropped_byte_count = drop_bytes_r;
  assign out_dropped_line_count = drop_lines_r;
  assign out_record_count       = records_r;

  // result is only shown once the sequencer is back in idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == lalrb_pkg::ST_IDLE))
    else $error("result strobe while busy");

  // head moves only on an accepted append
  a_head_append: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (head_r != $past(head_r))) |->
      $past(accept && (in_mode == lalrb_pkg::MODE_APPEND)))
    else $error("head moved without append request");

  // every scan read issue is followed by a scan compare
  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lalrb_pkg::ST_SCAN_RD && !scan_empty) |=>
      (state_r == lalrb_pkg::ST_SCAN_WAIT))
    else $error("scan read not followed by compare");

endmodule

`default_nettype wire
